// File: src/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg: shared types, widths and helper for the 3x3 matrix inverse
// Element format, internal precisions and the saturation helper.
// ----------------------------------------------------------------------------
package mi3_pkg;

   localparam int ELEM_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int NLANE      = 9;
   localparam int SHIFT      = 2 * FRAC_BITS;
   localparam int PROD_W     = 2 * ELEM_WIDTH;
   localparam int COF_W      = PROD_W + 1;
   localparam int DET_W      = 3 * ELEM_WIDTH + 3;
   localparam int NUM_W      = COF_W + SHIFT;
   localparam int REM_W      = (DET_W + ELEM_WIDTH > NUM_W) ? DET_W + ELEM_WIDTH : NUM_W;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = 2;

   // cofactor lane l = a[p]*a[q] - a[r]*a[s], column-major element index
   localparam int COF_SEL [NLANE][4] = '{
      '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
      '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
      '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}};

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;

   typedef struct packed {
      elem_type value;
      logic     clip;
   } sat_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [NLANE-1:0][COF_W-1:0] cof_mag;
      logic [NLANE-1:0]            cof_neg;
      logic [DET_W-1:0]            det_mag;
      logic                        det_neg;
      logic                        singular;
      elem_type                    det_field;
      logic                        det_clip;
   } cls_type;

   typedef struct packed {
      logic [DET_W-1:0] det_mag;
      logic [NLANE-1:0] neg;
      logic [NLANE-1:0] ovf;
      logic             singular;
      elem_type         det_field;
      logic             det_clip;
   } dctl_type;

   typedef struct packed {
      elem_type                         det;
      logic [NLANE-1:0][ELEM_WIDTH-1:0] inv;
      logic                             singular;
      logic                             saturated;
   } rsp_type;

   // clip a magnitude with a sign to the signed element range
   function automatic sat_type saturate(input logic [DET_W-1:0] mag, input logic neg);
      sat_type          r;
      logic [DET_W-1:0] half;
      half = DET_W'(1) << (ELEM_WIDTH - 1);
      if (neg) begin
         r.clip  = mag > half;
         r.value = r.clip ? elem_type'(half[ELEM_WIDTH-1:0])
                          : elem_type'(-mag[ELEM_WIDTH-1:0]);
      end else begin
         r.clip  = mag >= half;
         r.value = r.clip ? elem_type'(half[ELEM_WIDTH-1:0] - 1'b1)
                          : elem_type'(mag[ELEM_WIDTH-1:0]);
      end
      return r;
   endfunction

endpackage

// File: src/mat3_inverse_top.sv
// ----------------------------------------------------------------------------
// mat3_inverse_top: 3x3 matrix inverse by the adjugate, Q16.16
// Streams one matrix in and one inverse plus determinant out per word.
//
// Usage:
//   req channel: one word is one matrix, nine signed Q16.16 elements in
//   column-major order (a11 a21 a31 a12 ... a33). rsp channel: one word per
//   matrix with the nine saturated inverse elements and the determinant;
//   rsp_tuser flags a singular matrix and any clipped value.
//   From acceptance to rsp_tvalid a Q16.16 matrix passes six front stages,
//   the queue memory, one divider setup stage, one stage per quotient bit
//   and the output register.
//   Throughput is one matrix per cycle while rsp_tready is high, set by the
//   fully pipelined divider (nine lanes, one quotient bit per stage).
//   The front and the divider stall separately; a four-entry queue sits
//   between them. When the receiver holds rsp_tready low the divider
//   freezes, the queue fills, then req_tready drops.
//   Synchronous reset empties every pipeline and the queue; data registers
//   are not cleared. Nothing is kept between matrices.
// ----------------------------------------------------------------------------
module mat3_inverse_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [287:0] req_tdata,   // a11 a21 a31 a12 a22 a32 a13 a23 a33, 32 b each
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [319:0] rsp_tdata,   // b11 b21 b31 b12 b22 b32 b13 b23 b33 determinant
   output logic [1:0]   rsp_tuser    // singular, saturated
);

   localparam int EW = mi3_pkg::ELEM_WIDTH;

   logic [mi3_pkg::NLANE-1:0][EW-1:0] elems;
   logic             fr_valid;
   logic             fr_ready;
   mi3_pkg::cls_type fr_data;
   logic             bk_valid;
   logic             bk_ready;
   mi3_pkg::cls_type bk_data;
   mi3_pkg::rsp_type rsp;

   // unpack: first field in the lowest bits
   assign elems = req_tdata;

   mi3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_elems  (elems),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_data  (fr_data)
   );

   // decouple front and divider
   mi3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  (bk_data)
   );

   mi3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (bk_valid),
      .in_ready  (bk_ready),
      .in_data   (bk_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   // pack results: inverse elements low, determinant on top
   assign rsp_tdata = {rsp.det, rsp.inv};
   assign rsp_tuser = {rsp.saturated, rsp.singular};

   // singular result carries zero data and no clip flag
   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0 && !rsp_tuser[1]))
      else $error("singular result with nonzero data");

   // a full queue with a waiting front item must stall the input
   a_front_stall : assert property (@(posedge clock) disable iff (reset)
      (fr_valid && !fr_ready) |-> !req_tready)
      else $error("input accepted while front is blocked");

   // an item leaving the queue must find the divider ready to take it
   a_queue_pop : assert property (@(posedge clock) disable iff (reset)
      (bk_valid && bk_ready) |=> $past(!rsp_tvalid || rsp_tready))
      else $error("queue popped while divider stalled");

endmodule

// File: src/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front: cofactor and determinant pipeline
// Six stages: products, cofactors, split products, partial sums, determinant,
// classification.
// ----------------------------------------------------------------------------
module mi3_front (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  logic [mi3_pkg::NLANE-1:0][mi3_pkg::ELEM_WIDTH-1:0] in_elems,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output mi3_pkg::cls_type                              out_data
);

   localparam int EW = mi3_pkg::ELEM_WIDTH;
   localparam int NL = mi3_pkg::NLANE;
   localparam int PW = mi3_pkg::PROD_W;
   localparam int CW = mi3_pkg::COF_W;
   localparam int DW = mi3_pkg::DET_W;
   localparam int SW = PW + 3;

   logic [6:1] valid_ff;
   logic       adv;

   logic signed [PW-1:0]   s1_prod_in [NL][2];
   logic signed [PW-1:0]   s1_prod_ff [NL][2];
   logic signed [EW-1:0]   s1_row_in [3];
   logic signed [EW-1:0]   s1_row_ff [3];
   logic signed [CW-1:0]   s2_cof_in [NL];
   logic signed [CW-1:0]   s2_cof_ff [NL];
   logic signed [EW-1:0]   s2_row_ff [3];
   logic signed [PW:0]     s3_lo_in [3];
   logic signed [PW:0]     s3_lo_ff [3];
   logic signed [PW:0]     s3_hi_in [3];
   logic signed [PW:0]     s3_hi_ff [3];
   logic signed [CW-1:0]   s3_cof_ff [NL];
   logic signed [SW-1:0]   s4_lo_in;
   logic signed [SW-1:0]   s4_lo_ff;
   logic signed [SW-1:0]   s4_hi_in;
   logic signed [SW-1:0]   s4_hi_ff;
   logic signed [CW-1:0]   s4_cof_ff [NL];
   logic signed [DW-1:0]   s5_det_in;
   logic signed [DW-1:0]   s5_det_ff;
   logic signed [CW-1:0]   s5_cof_ff [NL];
   mi3_pkg::cls_type       s6_cls_in;
   mi3_pkg::cls_type       s6_cls_ff;

   assign adv       = !valid_ff[6] || out_ready;
   assign in_ready  = adv;
   assign out_valid = valid_ff[6];
   assign out_data  = s6_cls_ff;

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         s1_prod_in[l][0] = $signed(in_elems[mi3_pkg::COF_SEL[l][0]])
                          * $signed(in_elems[mi3_pkg::COF_SEL[l][1]]);
         s1_prod_in[l][1] = $signed(in_elems[mi3_pkg::COF_SEL[l][2]])
                          * $signed(in_elems[mi3_pkg::COF_SEL[l][3]]);
         s2_cof_in[l] = CW'(s1_prod_ff[l][0]) - CW'(s1_prod_ff[l][1]);
      end
      for (int j = 0; j < 3; j++) begin
         s1_row_in[j] = $signed(in_elems[3*j]);
         // split cofactor: low word unsigned, high part signed
         s3_lo_in[j] = s2_row_ff[j] * $signed({1'b0, s2_cof_ff[j][EW-1:0]});
         s3_hi_in[j] = s2_row_ff[j] * $signed(s2_cof_ff[j][CW-1:EW]);
      end
      s4_lo_in  = SW'(s3_lo_ff[0]) + SW'(s3_lo_ff[1]) + SW'(s3_lo_ff[2]);
      s4_hi_in  = SW'(s3_hi_ff[0]) + SW'(s3_hi_ff[1]) + SW'(s3_hi_ff[2]);
      s5_det_in = (DW'(s4_hi_ff) <<< EW) + DW'(s4_lo_ff);
   end

   always_comb begin
      mi3_pkg::sat_type dsat;
      logic [DW-1:0]    dmag;
      for (int l = 0; l < NL; l++) begin
         s6_cls_in.cof_neg[l] = s5_cof_ff[l][CW-1];
         s6_cls_in.cof_mag[l] = s5_cof_ff[l][CW-1] ? CW'(-s5_cof_ff[l]) : CW'(s5_cof_ff[l]);
      end
      dmag = s5_det_ff[DW-1] ? DW'(-s5_det_ff) : DW'(s5_det_ff);
      dsat = mi3_pkg::saturate(dmag >> mi3_pkg::SHIFT, s5_det_ff[DW-1]);
      s6_cls_in.det_mag   = dmag;
      s6_cls_in.det_neg   = s5_det_ff[DW-1];
      s6_cls_in.singular  = (s5_det_ff == '0);
      s6_cls_in.det_field = dsat.value;
      s6_cls_in.det_clip  = dsat.clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[5:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff <= s1_prod_in;
         s1_row_ff  <= s1_row_in;
         s2_cof_ff  <= s2_cof_in;
         s2_row_ff  <= s1_row_ff;
         s3_lo_ff   <= s3_lo_in;
         s3_hi_ff   <= s3_hi_in;
         s3_cof_ff  <= s2_cof_ff;
         s4_lo_ff   <= s4_lo_in;
         s4_hi_ff   <= s4_hi_in;
         s4_cof_ff  <= s3_cof_ff;
         s5_det_ff  <= s5_det_in;
         s5_cof_ff  <= s4_cof_ff;
         s6_cls_ff  <= s6_cls_in;
      end
   end

endmodule

// File: src/mi3_queue.sv
// ----------------------------------------------------------------------------
// mi3_queue: short FIFO between front and back
// Four entries of classified items.
// ----------------------------------------------------------------------------
module mi3_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mi3_pkg::cls_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output mi3_pkg::cls_type out_data
);

   localparam int PW = mi3_pkg::QPTR_W;

   mi3_pkg::cls_type mem_ff [mi3_pkg::QDEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW:0]      count_ff;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != (PW+1)'(mi3_pkg::QDEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

endmodule

// File: src/mi3_back.sv
// ----------------------------------------------------------------------------
// mi3_back: nine-lane pipelined restoring divider and output register
// One setup stage, one stage per quotient bit, then saturation.
// ----------------------------------------------------------------------------
module mi3_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mi3_pkg::cls_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output mi3_pkg::rsp_type out_data
);

   localparam int EW = mi3_pkg::ELEM_WIDTH;
   localparam int NL = mi3_pkg::NLANE;
   localparam int RW = mi3_pkg::REM_W;
   localparam int DW = mi3_pkg::DET_W;

   logic                dv_valid_ff [EW+1];
   logic [RW-1:0]       dv_rem_in   [EW+1][NL];
   logic [RW-1:0]       dv_rem_ff   [EW+1][NL];
   logic [EW-1:0]       dv_quo_in   [EW+1][NL];
   logic [EW-1:0]       dv_quo_ff   [EW+1][NL];
   mi3_pkg::dctl_type   dv_ctl_in;
   mi3_pkg::dctl_type   dv_ctl_ff   [EW+1];
   logic                out_valid_ff;
   mi3_pkg::rsp_type    out_data_in;
   mi3_pkg::rsp_type    out_data_ff;
   logic                adv;

   assign adv       = !out_valid_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // setup: overflow when |c|*2^SHIFT >= |det|*2^EW, else quotient fits EW bits;
   // then one quotient bit per stage, most significant first
   always_comb begin
      logic [RW-1:0] top_sh;
      logic [RW-1:0] dsh;
      logic          ge;
      top_sh = RW'(in_data.det_mag) << EW;
      dv_ctl_in.det_mag   = in_data.det_mag;
      dv_ctl_in.singular  = in_data.singular;
      dv_ctl_in.det_field = in_data.det_field;
      dv_ctl_in.det_clip  = in_data.det_clip;
      for (int l = 0; l < NL; l++) begin
         dv_rem_in[0][l]   = RW'(in_data.cof_mag[l]) << mi3_pkg::SHIFT;
         dv_quo_in[0][l]   = '0;
         dv_ctl_in.ovf[l]  = dv_rem_in[0][l] >= top_sh;
         dv_ctl_in.neg[l]  = in_data.cof_neg[l] ^ in_data.det_neg;
      end
      for (int k = 1; k <= EW; k++) begin
         dsh = RW'(dv_ctl_ff[k-1].det_mag) << (EW - k);
         for (int l = 0; l < NL; l++) begin
            ge = dv_rem_ff[k-1][l] >= dsh;
            dv_rem_in[k][l] = ge ? dv_rem_ff[k-1][l] - dsh : dv_rem_ff[k-1][l];
            dv_quo_in[k][l] = {dv_quo_ff[k-1][l][EW-2:0], ge};
         end
      end
   end

   always_comb begin
      mi3_pkg::sat_type  s;
      mi3_pkg::dctl_type c;
      logic              clip;
      c    = dv_ctl_ff[EW];
      clip = c.det_clip;
      for (int l = 0; l < NL; l++) begin
         s = mi3_pkg::saturate(DW'(dv_quo_ff[EW][l]), c.neg[l]);
         if (c.ovf[l]) begin
            s.clip  = 1'b1;
            s.value = c.neg[l] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
         end
         clip = clip | s.clip;
         out_data_in.inv[l] = c.singular ? '0 : s.value;
      end
      out_data_in.det       = c.singular ? '0 : c.det_field;
      out_data_in.singular  = c.singular;
      out_data_in.saturated = !c.singular && clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= EW; k++) dv_valid_ff[k] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         dv_valid_ff[0] <= in_valid;
         for (int k = 1; k <= EW; k++) dv_valid_ff[k] <= dv_valid_ff[k-1];
         out_valid_ff <= dv_valid_ff[EW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ctl_ff[0] <= dv_ctl_in;
         for (int k = 1; k <= EW; k++) dv_ctl_ff[k] <= dv_ctl_ff[k-1];
         for (int k = 0; k <= EW; k++) begin
            dv_rem_ff[k] <= dv_rem_in[k];
            dv_quo_ff[k] <= dv_quo_in[k];
         end
         out_data_ff <= out_data_in;
      end
   end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 3x3 matrix inverse
// Streams directed and random matrices into the block, predicts each inverse
// and determinant not typed in with exact wide arithmetic, and compares every
// returned word field by field, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDE       = 256;
   localparam int WDOG_MAX   = 20000;
   localparam int NRAND      = 320;
   localparam int NLANE      = mi3_pkg::NLANE;
   localparam int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH;
   localparam int FRAC_BITS  = mi3_pkg::FRAC_BITS;
   localparam int SHIFT      = mi3_pkg::SHIFT;

   typedef mi3_pkg::elem_type elem_type;
   typedef logic signed [WIDE-1:0] wide_type;

   // one inverse word as the predictor sees it
   typedef struct {
      logic [NLANE-1:0][ELEM_WIDTH-1:0] inv;
      elem_type                         det;
      logic                             singular;
      logic                             saturated;
   } inverse_type;

   // directed row: matrix plus optional typed-in answer
   typedef struct {
      logic [NLANE-1:0][ELEM_WIDTH-1:0] mat;
      bit                               has_answer;
      inverse_type                      answer;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [287:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [319:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   mat3_inverse_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   inverse_type pending_inverses[$];
   int          mismatch_count;
   int          idle_cycles;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_off;
   bit          stim_done;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // clip a wide signed value to the element range, flag any clipping
   function automatic elem_type clip_elem(input wide_type v, inout logic sat);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (ELEM_WIDTH - 1)) - 1;
      lo = -(wide_type'(1) <<< (ELEM_WIDTH - 1));
      if (v > hi) begin
         sat = 1'b1;
         return elem_type'(hi);
      end
      if (v < lo) begin
         sat = 1'b1;
         return elem_type'(lo);
      end
      return elem_type'(v);
   endfunction

   // exact adjugate inverse: cofactor * 2^SHIFT / det, truncated toward zero
   function automatic inverse_type predict_inverse(
         input logic [NLANE-1:0][ELEM_WIDTH-1:0] m);
      inverse_type r;
      wide_type    e[NLANE];
      wide_type    cof[NLANE];
      wide_type    det, num, q, dmag;
      logic        sat;
      sat = 1'b0;
      for (int i = 0; i < NLANE; i++) e[i] = wide_type'(signed'(m[i]));
      cof[0] = e[4]*e[8] - e[7]*e[5];
      cof[1] = e[7]*e[2] - e[1]*e[8];
      cof[2] = e[1]*e[5] - e[4]*e[2];
      cof[3] = e[6]*e[5] - e[3]*e[8];
      cof[4] = e[0]*e[8] - e[6]*e[2];
      cof[5] = e[3]*e[2] - e[0]*e[5];
      cof[6] = e[3]*e[7] - e[6]*e[4];
      cof[7] = e[6]*e[1] - e[0]*e[7];
      cof[8] = e[0]*e[4] - e[3]*e[1];
      det = e[0]*cof[0] + e[3]*cof[1] + e[6]*cof[2];
      r.inv = '0;
      r.det = '0;
      r.singular = (det == 0);
      r.saturated = 1'b0;
      if (r.singular) return r;
      dmag = (det < 0) ? -det : det;
      for (int i = 0; i < NLANE; i++) begin
         num = ((cof[i] < 0) ? -cof[i] : cof[i]) <<< SHIFT;
         q = num / dmag;
         if ((cof[i] < 0) != (det < 0)) q = -q;
         r.inv[i] = clip_elem(q, sat);
      end
      q = dmag >>> SHIFT;
      if (det < 0) q = -q;
      r.det = clip_elem(q, sat);
      r.saturated = sat;
      return r;
   endfunction

   // offer one matrix at a falling edge and hold it until accepted;
   // return at the falling edge after acceptance with tvalid still high
   task automatic send_matrix(input logic [NLANE-1:0][ELEM_WIDTH-1:0] m,
                              input inverse_type answer);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= m;
      pending_inverses.push_back(answer);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [ELEM_WIDTH-1:0] rand_elem();
      case ($urandom_range(5))
         0: return $urandom;
         1: return ELEM_WIDTH'(signed'($urandom_range(8)) - 4) << FRAC_BITS;
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3: return $urandom_range(3) - 1;
         default: return ELEM_WIDTH'(signed'($urandom_range(131072) - 65536)) << 4;
      endcase
   endfunction

   // drain the expectation store before changing the idle pattern;
   // return at a falling edge
   task automatic wait_drain();
      while (pending_inverses.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // directed stimulus
   stim_row_type stim_table[$];

   task automatic build_table();
      stim_row_type row;
      logic [ELEM_WIDTH-1:0] one;
      one = ELEM_WIDTH'(1) << FRAC_BITS;
      // zero matrix: singular, all zero
      row.mat = '0; row.has_answer = 1;
      row.answer = '{inv: '0, det: '0, singular: 1'b1, saturated: 1'b0};
      stim_table.push_back(row);
      // identity: inverse is identity, determinant one
      row.mat = '0; row.mat[0] = one; row.mat[4] = one; row.mat[8] = one;
      row.answer = '{inv: row.mat, det: elem_type'(one), singular: 1'b0,
                     saturated: 1'b0};
      stim_table.push_back(row);
      // diagonal of smallest code: tiny determinant, huge inverse
      row.mat = '0; row.mat[0] = 1; row.mat[4] = 1; row.mat[8] = 1;
      row.answer.inv = '0;
      row.answer.inv[0] = 32'h7FFF_FFFF; row.answer.inv[4] = 32'h7FFF_FFFF;
      row.answer.inv[8] = 32'h7FFF_FFFF;
      row.answer.det = '0; row.answer.singular = 0; row.answer.saturated = 1;
      stim_table.push_back(row);
      // rows predicted rather than typed
      row.has_answer = 0;
      row.mat = '0; row.mat[0] = 32'h7FFF_FFFF; row.mat[4] = 32'h7FFF_FFFF;
      row.mat[8] = 32'h7FFF_FFFF; stim_table.push_back(row);
      row.mat = '0; row.mat[0] = 32'h8000_0000; row.mat[4] = 32'h8000_0000;
      row.mat[8] = 32'h8000_0000; stim_table.push_back(row);
      row.mat = '1; stim_table.push_back(row);
      row.mat = {NLANE{32'h8000_0000}}; stim_table.push_back(row);
      row.mat = {NLANE{32'h7FFF_FFFF}}; stim_table.push_back(row);
      row.mat = '0; row.mat[0] = one; row.mat[4] = 32'hFFFF_0000;
      row.mat[8] = 32'h0003_0000; stim_table.push_back(row);
      row.mat = '0; row.mat[6] = one; row.mat[4] = one; row.mat[2] = one;
      stim_table.push_back(row);
      row.mat = '0; row.mat[0] = 32'h8000_0000; row.mat[4] = 32'h7FFF_FFFF;
      row.mat[8] = 1; stim_table.push_back(row);
      for (int k = 0; k < 8; k++) begin
         for (int i = 0; i < NLANE; i++) row.mat[i] = $urandom;
         stim_table.push_back(row);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      inverse_type exp_inv;
      inverse_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.inv       = rsp_tdata[NLANE*ELEM_WIDTH-1:0];
         got.det       = rsp_tdata[319 -: ELEM_WIDTH];
         got.singular  = rsp_tuser[0];
         got.saturated = rsp_tuser[1];
         if (pending_inverses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected result word %h", rsp_tdata);
         end else begin
            exp_inv = pending_inverses.pop_front();
            if (got.inv !== exp_inv.inv || got.det !== exp_inv.det ||
                got.singular !== exp_inv.singular ||
                got.saturated !== exp_inv.saturated) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: inv %h det %h sing %b sat %b, expected inv %h det %h sing %b sat %b",
                           got.inv, got.det, got.singular, got.saturated,
                           exp_inv.inv, exp_inv.det, exp_inv.singular,
                           exp_inv.saturated);
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_off)
         idle_cycles <= 0;
      else if (!stim_done) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_MAX) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      logic [NLANE-1:0][ELEM_WIDTH-1:0] m;
      int phase_pct[4][2];
      phase_pct = '{'{0, 0}, '{72, 0}, '{0, 72}, '{23, 23}};
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0; rsp_tready = 1'b0;
      mismatch_count = 0; idle_cycles = 0; hold_off = 0; stim_done = 0;
      send_idle_pct = 0; recv_stall_pct = 0;
      build_table();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // walk the directed table
      foreach (stim_table[i])
         send_matrix(stim_table[i].mat, stim_table[i].has_answer ?
                     stim_table[i].answer : predict_inverse(stim_table[i].mat));
      req_tvalid <= 1'b0;
      wait_drain();

      // back-pressure: hold the receiver off while the sender keeps going
      fork
         begin
            hold_off = 1;
            repeat (200) @(posedge clock);
            hold_off = 0;
         end
         begin
            for (int k = 0; k < 60; k++) begin
               for (int i = 0; i < NLANE; i++) m[i] = rand_elem();
               send_matrix(m, predict_inverse(m));
            end
            req_tvalid <= 1'b0;
         end
      join
      wait_drain();

      // random traffic across the idle phases
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = phase_pct[p][0];
         recv_stall_pct = phase_pct[p][1];
         for (int k = 0; k < NRAND / 4; k++) begin
            for (int i = 0; i < NLANE; i++) m[i] = rand_elem();
            // occasional rank-deficient matrix: copy one column onto another
            if ($urandom_range(9) == 0)
               for (int r = 0; r < 3; r++) m[6 + r] = m[r];
            send_matrix(m, predict_inverse(m));
         end
         req_tvalid <= 1'b0;
         wait_drain();
      end

      stim_done = 1;
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pending_inverses.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
